### rtl/core/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int PRIORITY_BITS = 8;

    localparam int PRI_PORT_W = 8;
    localparam int PAYLOAD_W  = 32;
    localparam int COUNT_W    = $clog2(QUEUE_DEPTH + 1);

    // bits of the priority port kept in a slot
    localparam int PRI_KEEP = (PRIORITY_BITS < PRI_PORT_W) ? PRIORITY_BITS : PRI_PORT_W;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        CTL_IDLE = 1'b0,
        CTL_HOLD = 1'b1
    } ctl_state_t;

    typedef struct packed {
        logic exec;
    } ctl_cmd_t;

endpackage

`default_nettype wire

### rtl/core/spq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output spq_pkg::ctl_cmd_t      cmd
);
    import spq_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       accept;

    assign accept = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CTL_IDLE:
            begin
                if (accept)
                begin
                    state_next = CTL_HOLD;
                end
            end
            CTL_HOLD:
            begin
                // word taken this cycle, a new one may replace it
                if (!out_stall)
                begin
                    state_next = accept ? CTL_HOLD : CTL_IDLE;
                end
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid = 1'b0;
        in_stall  = 1'b0;
        case (state_reg)
            CTL_IDLE:
            begin
                out_valid = 1'b0;
                in_stall  = 1'b0;
            end
            CTL_HOLD:
            begin
                out_valid = 1'b1;
                in_stall  = out_stall;
            end
            default:
            begin
                out_valid = 1'b0;
                in_stall  = 1'b1;
            end
        endcase
    end

    assign cmd.exec = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/spq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire spq_pkg::ctl_cmd_t                 cmd,
    input  wire logic                              operation,
    input  wire logic [spq_pkg::PRI_PORT_W-1:0]    priority_req,
    input  wire logic [spq_pkg::PAYLOAD_W-1:0]     payload,
    output spq_pkg::status_t                       status,
    output logic [spq_pkg::PRI_PORT_W-1:0]         out_priority,
    output logic [spq_pkg::PAYLOAD_W-1:0]          out_payload,
    output logic                                   now_empty
);
    import spq_pkg::*;

    logic [PRIORITY_BITS-1:0] slot_pri_reg  [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] slot_pri_next [QUEUE_DEPTH];
    logic [PAYLOAD_W-1:0]     slot_pay_reg  [QUEUE_DEPTH];
    logic [PAYLOAD_W-1:0]     slot_pay_next [QUEUE_DEPTH];
    logic [COUNT_W-1:0]       occ_reg;
    logic [COUNT_W-1:0]       occ_next;

    status_t                  status_reg;
    status_t                  status_next;
    logic [PRI_PORT_W-1:0]    opri_reg;
    logic [PRI_PORT_W-1:0]    opri_next;
    logic [PAYLOAD_W-1:0]     opay_reg;
    logic [PAYLOAD_W-1:0]     opay_next;
    logic                     now_empty_reg;

    logic [PRIORITY_BITS-1:0] pri_new;
    logic [QUEUE_DEPTH-1:0]   ge;
    logic                     enq_ok;
    logic                     deq_ok;
    logic                     is_enq;

    always_comb
    begin
        pri_new = '0;
        for (int b = 0; b < PRI_KEEP; b++)
        begin
            pri_new[b] = priority_req[b];
        end
    end

    assign is_enq = (op_t'(operation) == OP_ENQ);
    assign enq_ok = is_enq && (occ_reg != COUNT_W'(QUEUE_DEPTH));
    assign deq_ok = !is_enq && (occ_reg != '0);

    // per-slot compare, a prefix of ones since the slots stay sorted
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            ge[i] = (COUNT_W'(i) < occ_reg) && (slot_pri_reg[i] >= pri_new);
        end
    end

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            slot_pri_next[i] = slot_pri_reg[i];
            slot_pay_next[i] = slot_pay_reg[i];
        end
        if (enq_ok)
        begin
            if (!ge[0])
            begin
                slot_pri_next[0] = pri_new;
                slot_pay_next[0] = payload;
            end
            for (int i = 1; i < QUEUE_DEPTH; i++)
            begin
                if (!ge[i])
                begin
                    if (ge[i-1])
                    begin
                        slot_pri_next[i] = pri_new;
                        slot_pay_next[i] = payload;
                    end
                    else
                    begin
                        slot_pri_next[i] = slot_pri_reg[i-1];
                        slot_pay_next[i] = slot_pay_reg[i-1];
                    end
                end
            end
        end
        else if (deq_ok)
        begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                slot_pri_next[i] = slot_pri_reg[i+1];
                slot_pay_next[i] = slot_pay_reg[i+1];
            end
        end
    end

    always_comb
    begin
        occ_next    = occ_reg;
        status_next = ST_OK;
        opri_next   = '0;
        opay_next   = '0;
        if (enq_ok)
        begin
            occ_next = occ_reg + COUNT_W'(1);
        end
        else if (deq_ok)
        begin
            occ_next  = occ_reg - COUNT_W'(1);
            opay_next = slot_pay_reg[0];
            for (int b = 0; b < PRI_KEEP; b++)
            begin
                opri_next[b] = slot_pri_reg[0][b];
            end
        end
        else if (is_enq)
        begin
            status_next = ST_FULL;
        end
        else
        begin
            status_next = ST_EMPTY;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                slot_pri_reg[i] <= slot_pri_next[i];
                slot_pay_reg[i] <= slot_pay_next[i];
            end
            status_reg <= status_next;
            opri_reg   <= opri_next;
            opay_reg   <= opay_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            now_empty_reg <= 1'b1;
        end
        else if (cmd.exec)
        begin
            occ_reg       <= occ_next;
            now_empty_reg <= (occ_next == '0);
        end
    end

    assign status       = status_reg;
    assign out_priority = opri_reg;
    assign out_payload  = opay_reg;
    assign now_empty    = now_empty_reg;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= COUNT_W'(QUEUE_DEPTH))
        else $error("occupancy above queue depth");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && is_enq && (occ_reg == COUNT_W'(QUEUE_DEPTH))
        |=> $stable(occ_reg) && (status_reg == ST_FULL))
        else $error("enqueue into full queue changed occupancy");

    a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && !is_enq && (occ_reg != '0)
        |=> (occ_reg == $past(occ_reg) - COUNT_W'(1)) && (status_reg == ST_OK))
        else $error("dequeue did not remove one entry");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> now_empty_reg == (occ_reg == '0))
        else $error("empty flag disagrees with occupancy");
`endif

endmodule

`default_nettype wire

### rtl/core/stable_priority_queue.sv
// latency: a result word is valid the cycle after its input word is accepted
// throughput: one word per cycle while not stalled, the sorted slot row compares and shifts in one step
// an input word is stalled only while a result word is held under out_stall
// reset: rst_n asynchronous active low, queue empty, no result pending
// slot contents are not reset, slots at or above the occupancy never reach an output
`timescale 1ns / 1ps
`default_nettype none

module stable_priority_queue (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic                             operation,
    input  wire logic [spq_pkg::PRI_PORT_W-1:0]   priority_req,
    input  wire logic [spq_pkg::PAYLOAD_W-1:0]    payload,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [1:0]                            status,
    output logic [spq_pkg::PRI_PORT_W-1:0]        out_priority,
    output logic [spq_pkg::PAYLOAD_W-1:0]         out_payload,
    output logic                                  now_empty
);
    import spq_pkg::*;

    ctl_cmd_t cmd;
    status_t  dp_status;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    spq_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .operation    (operation),
        .priority_req (priority_req),
        .payload      (payload),
        .status       (dp_status),
        .out_priority (out_priority),
        .out_payload  (out_payload),
        .now_empty    (now_empty)
    );

    assign status = dp_status;

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import spq_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRINT_LIMIT    = 40;
    // priority bits the queue keeps
    localparam logic [PRI_PORT_W-1:0] KEEP_MASK = {PRI_PORT_W{1'b1}} >> (PRI_PORT_W - PRI_KEEP);

    typedef struct {
        logic [PRI_PORT_W-1:0] pri;
        logic [PAYLOAD_W-1:0]  tag;
    } entry_t;

    typedef struct {
        status_t               status;
        logic [PRI_PORT_W-1:0] pri;
        logic [PAYLOAD_W-1:0]  tag;
        logic                  empty;
    } result_t;

    class queue_scoreboard;
        entry_t      held[$];
        result_t     awaited[$];
        int unsigned mismatches;

        function void flag(string what, logic [PAYLOAD_W-1:0] exp_val,
                           logic [PAYLOAD_W-1:0] act_val);
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("%0t: %s expected %0h, got %0h", $time, what, exp_val, act_val);
        endfunction

        // sorted mirror of the queue, ties keep arrival order
        function void note_word(op_t op, logic [PRI_PORT_W-1:0] pri_in,
                                logic [PAYLOAD_W-1:0] tag_in);
            entry_t  e;
            result_t r;
            int      pos;
            r.status = ST_OK;
            r.pri    = '0;
            r.tag    = '0;
            if (op == OP_ENQ) begin
                if (held.size() >= QUEUE_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    e.pri = pri_in & KEEP_MASK;
                    e.tag = tag_in;
                    pos = 0;
                    while (pos < held.size() && held[pos].pri >= e.pri)
                        pos++;
                    held.insert(pos, e);
                end
            end
            else
            begin
                if (held.size() == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    e = held.pop_front();
                    r.pri = e.pri;
                    r.tag = e.tag;
                end
            end
            r.empty = (held.size() == 0);
            awaited.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic [PRI_PORT_W-1:0] pri_out,
                                   logic [PAYLOAD_W-1:0] tag_out, logic empty_out);
            result_t r;
            if (awaited.size() == 0) begin
                flag("unexpected result word, status", {PAYLOAD_W{1'bx}}, PAYLOAD_W'(st));
                return;
            end
            r = awaited.pop_front();
            if (st !== r.status)
                flag("status", PAYLOAD_W'(r.status), PAYLOAD_W'(st));
            if (pri_out !== r.pri)
                flag("out_priority", PAYLOAD_W'(r.pri), PAYLOAD_W'(pri_out));
            if (tag_out !== r.tag)
                flag("out_payload", r.tag, tag_out);
            if (empty_out !== r.empty)
                flag("now_empty", PAYLOAD_W'(r.empty), PAYLOAD_W'(empty_out));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  operation;
    logic [PRI_PORT_W-1:0] priority_req;
    logic [PAYLOAD_W-1:0]  payload;
    logic                  out_valid;
    logic                  out_stall;
    logic [1:0]            status;
    logic [PRI_PORT_W-1:0] out_priority;
    logic [PAYLOAD_W-1:0]  out_payload;
    logic                  now_empty;

    queue_scoreboard sb = new();
    int unsigned     words_in;
    int unsigned     quiet_cycles;
    int unsigned     in_idle_pct;
    int unsigned     out_stall_pct;

    stable_priority_queue dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .priority_req (priority_req),
        .payload      (payload),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .out_priority (out_priority),
        .out_payload  (out_payload),
        .now_empty    (now_empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                sb.note_word(op_t'(operation), priority_req, payload);
                words_in++;
            end
            if (out_valid && !out_stall)
                sb.check_result(status, out_priority, out_payload, now_empty);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !(in_valid && !in_stall) && !(out_valid && !out_stall)) begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
        else
            quiet_cycles = 0;
    end

    // result side stall bursts
    initial
    begin
        int unsigned burst;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rst_n && $urandom_range(1, 100) <= out_stall_pct) begin
                burst = $urandom_range(1, 17);
                out_stall = 1'b1;
                repeat (burst) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_word(input op_t op, input logic [PRI_PORT_W-1:0] pri,
                             input logic [PAYLOAD_W-1:0] tag);
        int unsigned seen;
        if ($urandom_range(1, 100) <= in_idle_pct) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        operation    = op;
        priority_req = pri;
        payload      = tag;
        in_valid     = 1'b1;
        seen = words_in;
        do
            @(negedge clk);
        while (words_in == seen);
    endtask

    initial
    begin
        int unsigned           n;
        int unsigned           enq_pct;
        op_t                   op;
        logic [PRI_PORT_W-1:0] pri;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        operation     = OP_ENQ;
        priority_req  = '0;
        payload       = '0;
        words_in      = 0;
        quiet_cycles  = 0;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty dequeue, extremes, ties, fill past full, a few removals
        send_word(OP_DEQ, 8'hFF, 32'hFFFF_FFFF);
        send_word(OP_ENQ, 8'h00, 32'h0000_0000);
        send_word(OP_ENQ, 8'hFF, 32'hFFFF_FFFF);
        send_word(OP_ENQ, 8'h07, 32'h0000_0001);
        send_word(OP_ENQ, 8'h07, 32'h0000_0002);
        send_word(OP_DEQ, 8'h00, 32'h0000_0000);
        send_word(OP_ENQ, 8'h07, 32'h0000_0003);
        send_word(OP_ENQ, 8'hAA, 32'hA5A5_A5A5);
        send_word(OP_ENQ, 8'h55, 32'h5A5A_5A5A);
        for (int i = 0; i < 10; i++) begin
            case (i % 3)
                0: pri = 8'h00;
                1: pri = 8'h07;
                default: pri = 8'hFF;
            endcase
            send_word(OP_ENQ, pri, 32'h1000_0000 + i);
        end
        send_word(OP_ENQ, 8'hFF, 32'hDEAD_BEEF);
        send_word(OP_ENQ, 8'h00, 32'hFFFF_FFFF);
        repeat (3) send_word(OP_DEQ, 8'h55, 32'h0F0F_0F0F);

        // random segments, each with its own fill bias and idling
        for (int seg = 0; seg < 17; seg++) begin
            if (seg == 16) begin
                n = 60;
                enq_pct = 50;
                in_idle_pct = 0;
                out_stall_pct = 0;
            end
            else
            begin
                n = 40;
                case ($urandom_range(0, 3))
                    0: enq_pct = 25;
                    1: enq_pct = 50;
                    2: enq_pct = 75;
                    default: enq_pct = 90;
                endcase
                case ($urandom_range(0, 2))
                    0: in_idle_pct = 0;
                    1: in_idle_pct = 10;
                    default: in_idle_pct = 35;
                endcase
                case ($urandom_range(0, 2))
                    0: out_stall_pct = 0;
                    1: out_stall_pct = 10;
                    default: out_stall_pct = 35;
                endcase
            end
            repeat (n)
            begin
                op = ($urandom_range(1, 100) <= enq_pct) ? OP_ENQ : OP_DEQ;
                // small priorities often, so ties are common
                case ($urandom_range(0, 3))
                    0: pri = PRI_PORT_W'($urandom_range(0, 3));
                    1: pri = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    default: pri = PRI_PORT_W'($urandom_range(0, 255));
                endcase
                send_word(op, pri, $urandom);
            end
        end
        in_valid = 1'b0;

        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
